FILE: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: operation codes, widths and shared types.
`default_nettype none
package rau_pkg;

   localparam int OperandWidthDefault = 16;
   localparam int NumOutWidth = 33;
   localparam int DenOutWidth = 32;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SUM,
      BK_GCD,
      BK_DIVN,
      BK_DIVD,
      BK_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_MUL,
      FR_PUSH
   } front_state_type;

endpackage
`default_nettype wire

FILE: rtl/core/rau_front.sv
// Front part: takes an item, forms sign-magnitude products and pushes them to the queue.
`default_nettype none
module rau_front
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault,
   localparam int MW = OPERAND_WIDTH + 1,
   localparam int PW = 2 * MW
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [1:0]               req_type,
   input  wire logic [OPERAND_WIDTH-1:0] req_a_num,
   input  wire logic [OPERAND_WIDTH-1:0] req_a_den,
   input  wire logic [OPERAND_WIDTH-1:0] req_b_num,
   input  wire logic [OPERAND_WIDTH-1:0] req_b_den,
   output logic                          push,
   output logic [4*PW+3:0]               push_data,
   input  wire logic                     full
);

   front_state_type state_ff, state_in;
   logic [MW-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic [1:0] op_ff;
   logic [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [PW-1:0] p0_in, p1_in, p2_in, p3_in;
   logic s0_ff, s1_ff, s2_ff, s3_ff;
   logic s0_in, s1_in, s2_in, s3_in;
   logic [PW-1:0] ad_x_bd;

   function automatic logic [MW-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
      logic [MW-1:0] ext;
      begin
         ext = {v[OPERAND_WIDTH-1], v};
         mag_of = v[OPERAND_WIDTH-1] ? (~ext + 1'b1) : ext;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: if (start) state_in = FR_MUL;
         FR_MUL:  state_in = FR_PUSH;
         FR_PUSH: if (!full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != FR_IDLE);
      push = (state_ff == FR_PUSH) && !full;
   end

   // Operands are latched as sign and magnitude; the sign of b's numerator is inverted for subtract.
   always_ff @(posedge clock) begin
      if (state_ff == FR_IDLE && start) begin
         op_ff     <= req_type;
         an_ff     <= mag_of(req_a_num);
         ad_ff     <= mag_of(req_a_den);
         bn_ff     <= mag_of(req_b_num);
         bd_ff     <= mag_of(req_b_den);
         an_neg_ff <= req_a_num[OPERAND_WIDTH-1];
         ad_neg_ff <= req_a_den[OPERAND_WIDTH-1];
         bn_neg_ff <= req_b_num[OPERAND_WIDTH-1] ^ (req_type == OP_SUB);
         bd_neg_ff <= req_b_den[OPERAND_WIDTH-1];
      end
   end

   // p0/p1 are the two numerator terms (p1 is zero for multiply and divide),
   // p2 the denominator, p3 unused but kept zero.
   assign ad_x_bd = PW'(ad_ff) * PW'(bd_ff);
   always_comb begin
      p3_in = '0;
      s3_in = 1'b0;
      case (op_ff)
         OP_MUL: begin
            p0_in = PW'(an_ff) * PW'(bn_ff);  s0_in = an_neg_ff ^ bn_neg_ff;
            p1_in = '0;                       s1_in = 1'b0;
            p2_in = ad_x_bd;                  s2_in = ad_neg_ff ^ bd_neg_ff;
         end
         OP_DIV: begin
            p0_in = PW'(an_ff) * PW'(bd_ff);  s0_in = an_neg_ff ^ bd_neg_ff;
            p1_in = '0;                       s1_in = 1'b0;
            p2_in = PW'(ad_ff) * PW'(bn_ff);  s2_in = ad_neg_ff ^ (bn_neg_ff ^ (op_ff == OP_SUB));
         end
         default: begin
            p0_in = PW'(an_ff) * PW'(bd_ff);  s0_in = an_neg_ff ^ bd_neg_ff;
            p1_in = PW'(bn_ff) * PW'(ad_ff);  s1_in = bn_neg_ff ^ ad_neg_ff;
            p2_in = ad_x_bd;                  s2_in = ad_neg_ff ^ bd_neg_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == FR_MUL) begin
         p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
         s0_ff <= s0_in; s1_ff <= s1_in; s2_ff <= s2_in; s3_ff <= s3_in;
      end
   end

   assign push_data = {s3_ff ^ s3_ff, s2_ff, s1_ff, s0_ff, p3_ff, p2_ff, p1_ff, p0_ff};

endmodule
`default_nettype wire

FILE: rtl/core/rau_queue.sv
// Short item queue between the front and back parts.
`default_nettype none
module rau_queue
   import rau_pkg::*;
#(
   parameter int DW = 8,
   parameter int DEPTH = QueueDepth
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire logic [DW-1:0] push_data,
   output logic               full,
   input  wire logic          pop,
   output logic               empty,
   output logic [DW-1:0]      pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [DW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push && !full)
            wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop && !empty)
            rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
      end
   end

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!push && !pop) |=> $stable(cnt_ff)) else $error("queue count drift");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (empty && !push) |=> empty) else $error("queue popped when empty");
endmodule
`default_nettype wire

FILE: rtl/core/rau_back.sv
// Back part: sums the terms, finds the gcd and divides it out with one shared restoring divider.
`default_nettype none
module rau_back
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault,
   localparam int MW = OPERAND_WIDTH + 1,
   localparam int PW = 2 * MW,
   localparam int VW = PW + 1,
   localparam int CW = $clog2(VW + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   empty,
   input  wire logic [4*PW+3:0]        pop_data,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic signed [NumOutWidth-1:0] rsp_res_num,
   output logic [DenOutWidth-1:0]      rsp_res_den,
   output logic                        rsp_status
);

   back_state_type state_ff, state_in;
   logic [VW-1:0] num_ff, den_ff, x_ff, y_ff;
   logic num_neg_ff, den_neg_ff;
   logic [PW-1:0] t0_ff, t1_ff;
   logic s0_ff, s1_ff;
   // Restoring divider: quotient q, remainder r, dividend shifting out of d.
   logic [VW-1:0] dq_ff, dr_ff, dd_ff, dv_ff;
   logic [CW-1:0] dcnt_ff;
   logic          div_run_ff, div_start;
   logic [VW-1:0] div_a, div_b;
   logic [VW:0]   trial;
   logic [VW-1:0] r_shift;
   logic [VW-1:0] sum_mag;
   logic          sum_neg;
   logic [VW-1:0] nres;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (!empty) state_in = BK_MUL;
         BK_MUL:  state_in = BK_SUM;
         BK_SUM: begin
            if (den_ff == '0 || num_ff == '0) state_in = BK_DONE;
            else                              state_in = BK_GCD;
         end
         BK_GCD: if (!div_run_ff && y_ff == '0) state_in = BK_DIVN;
         BK_DIVN: if (!div_run_ff && dcnt_ff == '0 && !div_start) state_in = BK_DIVD;
         BK_DIVD: if (!div_run_ff && dcnt_ff == '0 && !div_start) state_in = BK_DONE;
         BK_DONE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == BK_IDLE) && !empty;
   end

   always_comb begin
      if (s0_ff == s1_ff) begin
         sum_mag = VW'(t0_ff) + VW'(t1_ff); sum_neg = s0_ff;
      end else if (t0_ff >= t1_ff) begin
         sum_mag = VW'(t0_ff - t1_ff);     sum_neg = s0_ff;
      end else begin
         sum_mag = VW'(t1_ff - t0_ff);     sum_neg = s1_ff;
      end
   end

   // A divide is launched for each GCD remainder step while y is nonzero, and once each
   // for numerator and denominator reduction.
   logic divn_go_ff, divd_go_ff;
   always_comb begin
      div_start = 1'b0; div_a = x_ff; div_b = y_ff;
      case (state_ff)
         BK_GCD: begin
            div_start = !div_run_ff && (y_ff != '0);
         end
         BK_DIVN: begin
            div_start = divn_go_ff; div_a = num_ff; div_b = x_ff;
         end
         BK_DIVD: begin
            div_start = divd_go_ff; div_a = den_ff; div_b = x_ff;
         end
         default: ;
      endcase
   end

   assign r_shift = {dr_ff[VW-2:0], dd_ff[VW-1]};
   assign trial   = {1'b0, r_shift} - {1'b0, dv_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_run_ff <= 1'b0; dcnt_ff <= '0;
      end else if (div_start) begin
         div_run_ff <= 1'b1; dcnt_ff <= CW'(VW);
      end else if (div_run_ff) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (dcnt_ff == CW'(1)) div_run_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         dd_ff <= div_a; dv_ff <= div_b; dr_ff <= '0; dq_ff <= '0;
      end else if (div_run_ff) begin
         dd_ff <= {dd_ff[VW-2:0], 1'b0};
         if (!trial[VW]) begin
            dr_ff <= trial[VW-1:0]; dq_ff <= {dq_ff[VW-2:0], 1'b1};
         end else begin
            dr_ff <= r_shift;        dq_ff <= {dq_ff[VW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divn_go_ff <= 1'b0; divd_go_ff <= 1'b0;
      end else begin
         divn_go_ff <= (state_ff == BK_GCD) && (state_in == BK_DIVN);
         divd_go_ff <= (state_ff == BK_DIVN) && (state_in == BK_DIVD);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               t0_ff <= pop_data[PW-1:0];
               t1_ff <= pop_data[2*PW-1:PW];
               den_ff <= VW'(pop_data[3*PW-1:2*PW]);
               s0_ff <= pop_data[4*PW];
               s1_ff <= pop_data[4*PW+1];
               den_neg_ff <= pop_data[4*PW+2];
            end
         end
         BK_MUL: begin
            num_ff <= sum_mag; num_neg_ff <= sum_neg;
            x_ff <= sum_mag;   y_ff <= den_ff;
         end
         BK_GCD: begin
            if (div_run_ff && dcnt_ff == CW'(1)) begin
               x_ff <= y_ff;
               y_ff <= (!trial[VW]) ? trial[VW-1:0] : r_shift;
            end
         end
         BK_DIVN: if (div_run_ff && dcnt_ff == CW'(1))
            num_ff <= {dq_ff[VW-2:0], !trial[VW]};
         BK_DIVD: if (div_run_ff && dcnt_ff == CW'(1))
            den_ff <= {dq_ff[VW-2:0], !trial[VW]};
         default: ;
      endcase
   end

   assign nres = (num_neg_ff ^ den_neg_ff) ? (~num_ff + 1'b1) : num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == BK_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_DONE) begin
         if (den_ff == '0) begin
            rsp_res_num <= '0; rsp_res_den <= DenOutWidth'(1); rsp_status <= 1'b1;
         end else if (num_ff == '0) begin
            rsp_res_num <= '0; rsp_res_den <= DenOutWidth'(1); rsp_status <= 1'b0;
         end else begin
            rsp_res_num <= NumOutWidth'(nres);
            rsp_res_den <= DenOutWidth'(den_ff);
            rsp_status  <= 1'b0;
         end
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == BK_IDLE) else $error("pop outside idle");
   a_div_one: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_run_ff) else $error("divider restarted while running");
   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_b != '0) else $error("divide by zero launched");
endmodule
`default_nettype wire

FILE: rtl/core/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
`default_nettype none
// Rational arithmetic unit. Raise start for one cycle with an operation
// (0 add, 1 subtract, 2 multiply, 3 divide) and two signed fractions; the item
// is taken at an edge where start is high and busy is low. The front part
// latches the item, registers its cross products and places it in a
// two-entry queue, after which busy falls and another item can be taken; busy
// stays high while the item waits on a full queue. The back part reduces one item at a time
// with a single shared restoring divider of 2*OPERAND_WIDTH+3 bits, one
// quotient bit a cycle: Euclid's algorithm runs one such division per
// remainder step, and two more divisions strip the greatest common divisor
// from numerator and denominator, so the time to a result grows with the
// number of remainder steps. Items with a zero numerator or denominator skip
// the divider. Each result appears for exactly one cycle with rsp_valid high
// and must be taken then: the receiver cannot stall the block. The
// denominator is always positive and a zero numerator gives 0/1; a zero
// denominator gives 0/1 with rsp_status set.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = OperandWidthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [1:0]                 req_type,
   input  wire logic [OPERAND_WIDTH-1:0]   req_a_num,
   input  wire logic [OPERAND_WIDTH-1:0]   req_a_den,
   input  wire logic [OPERAND_WIDTH-1:0]   req_b_num,
   input  wire logic [OPERAND_WIDTH-1:0]   req_b_den,
   output logic                            rsp_valid,
   output logic signed [NumOutWidth-1:0]   rsp_res_num,
   output logic [DenOutWidth-1:0]          rsp_res_den,
   output logic                            rsp_status
);
   localparam int PW = 2 * (OPERAND_WIDTH + 1);
   localparam int DW = 4 * PW + 4;

   logic          push, full, pop, empty;
   logic [DW-1:0] push_data, pop_data;

   rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
      .clock, .reset, .start, .busy, .req_type,
      .req_a_num, .req_a_den, .req_b_num, .req_b_den,
      .push, .push_data, .full
   );

   rau_queue #(.DW(DW), .DEPTH(QueueDepth)) u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .empty, .pop_data
   );

   rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
      .clock, .reset, .empty, .pop_data, .pop,
      .rsp_valid, .rsp_res_num, .rsp_res_den, .rsp_status
   );
endmodule
`default_nettype wire

FILE: tb/sv/rau_checker.sv
// Checker for the rational arithmetic unit: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module rau_checker
   import rau_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     busy,
   input  wire logic [1:0]               req_type,
   input  wire logic [15:0]              req_a_num,
   input  wire logic [15:0]              req_a_den,
   input  wire logic [15:0]              req_b_num,
   input  wire logic [15:0]              req_b_den,
   input  wire logic                     rsp_valid,
   input  wire logic signed [32:0]       rsp_res_num,
   input  wire logic [31:0]              rsp_res_den,
   input  wire logic                     rsp_status,
   output int                            fail_count,
   output int                            pending
);

   typedef struct packed {
      logic [32:0] num;
      logic [31:0] den;
      logic        status;
   } fraction_type;

   fraction_type reduced_q[$];

   // Exact rational result as a signed 64-bit quantity; 16x16 products fit easily.
   function automatic fraction_type reduce_fraction(op_type op, logic signed [15:0] an,
                                                    logic signed [15:0] ad,
                                                    logic signed [15:0] bn,
                                                    logic signed [15:0] bd);
      longint n, d, g, x, y, t;
      fraction_type r;
      case (op)
         OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         OP_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      r.status = 1'b0;
      r.num = '0;
      r.den = 32'd1;
      if (d == 0) begin
         r.status = 1'b1;
      end else if (n != 0) begin
         x = (n < 0) ? -n : n;
         y = (d < 0) ? -d : d;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         g = x;
         x = ((n < 0) ? -n : n) / g;
         y = ((d < 0) ? -d : d) / g;
         if ((n < 0) != (d < 0)) x = -x;
         r.num = x[32:0];
         r.den = y[31:0];
      end
      return r;
   endfunction

   assign pending = reduced_q.size();

   always @(posedge clock) begin
      fraction_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy)
            reduced_q.push_back(reduce_fraction(op_type'(req_type), req_a_num, req_a_den,
                                                req_b_num, req_b_den));
         if (rsp_valid) begin
            if (reduced_q.size() == 0) begin
               $error("result with nothing expected: %0d/%0d", rsp_res_num, rsp_res_den);
               fail_count <= fail_count + 1;
            end else begin
               want = reduced_q.pop_front();
               if (rsp_res_num !== want.num || rsp_res_den !== want.den
                   || rsp_status !== want.status) begin
                  if (rsp_res_num !== want.num)
                     $error("res_num expected %0d got %0d", $signed(want.num), rsp_res_num);
                  if (rsp_res_den !== want.den)
                     $error("res_den expected %0d got %0d", want.den, rsp_res_den);
                  if (rsp_status !== want.status)
                     $error("status expected %0d got %0d", want.status, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: tb/sv/testbench.sv
// Top of the testbench for the rational arithmetic unit: stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
   import rau_pkg::*;

   // A quiet spell as long as this limit means a hang.
   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [1:0] req_type = OP_ADD;
   logic [15:0] req_a_num = '0, req_a_den = 16'd1, req_b_num = '0, req_b_den = 16'd1;
   logic busy, rsp_valid, rsp_status;
   logic signed [32:0] rsp_res_num;
   logic [31:0] rsp_res_den;
   int fail_count, pending;
   int quiet_cycles = 0;
   int items_sent = 0;
   int results_seen = 0;

   always #6 clock = ~clock;

   rational_arithmetic_unit dut (
      .clock, .reset, .start, .busy, .req_type, .req_a_num, .req_a_den,
      .req_b_num, .req_b_den, .rsp_valid, .rsp_res_num, .rsp_res_den, .rsp_status
   );

   rau_checker checker_i (
      .clock, .reset, .start, .busy, .req_type, .req_a_num, .req_a_den,
      .req_b_num, .req_b_den, .rsp_valid, .rsp_res_num, .rsp_res_den, .rsp_status,
      .fail_count, .pending
   );

   // The watchdog restarts whenever an item or a result crosses a channel.
   always @(posedge clock) begin
      if (rsp_valid) results_seen <= results_seen + 1;
      if ((start && !busy) || rsp_valid || reset) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Draws an operand, leaning on the edges of the range: zero, ones, the extremes.
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'h0001;
         4: return 16'hFFFF;
         5, 6: return 16'($signed($urandom_range(0, 40)) - 20);
         default: return 16'($urandom);
      endcase
   endfunction

   // Presents one item from the falling edge and holds it until the block takes it.
   // Start is lowered afterwards only when another item does not follow at once.
   task automatic send_item(op_type op, logic [15:0] an, logic [15:0] ad,
                            logic [15:0] bn, logic [15:0] bd);
      start <= 1'b1;
      req_type <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic idle_burst(int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   initial begin
      logic [15:0] ops[4];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items: every operation at the extremes, zero numerators and
      // denominators, negative denominators and fractions that reduce fully.
      send_item(OP_ADD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(OP_ADD, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
      send_item(OP_SUB, 16'h8000, 16'h0001, 16'h7FFF, 16'h0001);
      send_item(OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
      send_item(OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
      send_item(OP_MUL, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      send_item(OP_DIV, 16'd1, 16'h8000, 16'h8000, 16'd1);
      send_item(OP_DIV, 16'd5, 16'd7, 16'd0, 16'd3);
      send_item(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd2);
      send_item(OP_MUL, 16'd1, 16'd2, 16'd1, 16'd0);
      send_item(OP_MUL, 16'd0, 16'd5, 16'd9, 16'd7);
      send_item(OP_ADD, 16'd2, 16'hFFFD, 16'd1, 16'd3);
      send_item(OP_SUB, 16'hFFFF, 16'hFFFE, 16'd1, 16'hFFFC);
      send_item(OP_DIV, 16'hFFFF, 16'd3, 16'hFFFF, 16'hFFFD);
      send_item(OP_MUL, 16'd6, 16'd4, 16'd10, 16'd15);
      send_item(OP_DIV, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000);
      send_item(OP_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
      idle_burst(3);

      // Random items; in the last fifty there is no idling at all.
      for (int i = 0; i < 540; i++) begin
         foreach (ops[k]) ops[k] = pick_operand();
         send_item(op_type'($urandom_range(0, 3)), ops[0], ops[1], ops[2], ops[3]);
         if (i < 490 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 19));
      end
      start <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("Sent %0d items over all four operations, with zero, negative and",
               items_sent);
      $display("extreme operands; %0d results were compared.", results_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_queue.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
tb/sv/rau_checker.sv
tb/sv/testbench.sv
